// ===== design/cpt_pkg.sv =====
package cpt_pkg;

    // coordinate and internal widths
    localparam int CW  = 32;           // coordinate
    localparam int DW  = CW + 1;       // coordinate difference
    localparam int PW  = 2 * CW + 3;   // dot product
    localparam int SL  = CW + 2;       // multiplier slice
    localparam int HW  = PW - SL;      // upper slice of a dot product
    localparam int VW  = 4 * CW + 6;   // region determinant
    localparam int FW  = 4 * CW + 7;   // divisor
    localparam int NW  = 5 * CW + 7;   // dividend
    localparam int MW  = NW - 1;       // dividend magnitude, divider remainder
    localparam int QW  = CW + 1;       // quotient bits kept
    localparam int RSW = CW + 3;       // base plus quotient

    localparam logic signed [RSW-1:0] RES_HI = $signed({4'b0000, {(CW-1){1'b1}}});
    localparam logic signed [RSW-1:0] RES_LO = $signed({4'b1111, {(CW-1){1'b0}}});
    localparam logic [CW-1:0] CO_MAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CO_MIN = {1'b1, {(CW-1){1'b0}}};

    typedef enum logic [2:0] {
        REG_A    = 3'd0,
        REG_B    = 3'd1,
        REG_AB   = 3'd2,
        REG_C    = 3'd3,
        REG_AC   = 3'd4,
        REG_BC   = 3'd5,
        REG_FACE = 3'd6
    } t_region;

    typedef struct packed {
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic signed [CW-1:0] cz;
        logic signed [CW-1:0] px;
        logic signed [CW-1:0] py;
        logic signed [CW-1:0] pz;
    } t_in_beat;

    typedef struct packed {
        logic signed [CW-1:0] closest_x;
        logic signed [CW-1:0] closest_y;
        logic signed [CW-1:0] closest_z;
        t_region              region;
        logic                 degenerate;
    } t_out_beat;

endpackage

// ===== design/closest_point_on_triangle_unit.sv =====
// An accepted input beat passes pipeline stages 1 to NP, then the output register, before o_valid.
// One beat per cycle while o_ready is high; the pipeline holds 45 beats plus 2 at the output.
// Depth is set by the restoring divider, one quotient bit per stage over 33 stages.
// Reset: synchronous, active low; clears all valid flags, the datapath is not reset.
// Input stalls only when the output register and its skid slot are both full.
module closest_point_on_triangle_unit
    import cpt_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_beat  i_data,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_beat o_data
);

    localparam int NP = 12 + QW;   // last pipeline stage before the output register
    localparam int MX [6] = '{0, 2, 4, 0, 2, 4};
    localparam int MY [6] = '{3, 1, 1, 5, 5, 3};

    logic en;
    logic [NP:1] r_vld;
    logic r_out_vld, r_skid_vld;
    t_out_beat r_out, r_skid, n_out;

    logic signed [CW-1:0] in_a [3], in_b [3], in_c [3], in_p [3];

    logic signed [CW-1:0] r_a [1:6][3], r_b [1:6][3], r_c [1:6][3];
    logic signed [DW-1:0] r_ab [1:6][3], r_ac [1:6][3], r_bc [1:6][3];
    logic signed [DW-1:0] r_ap [3], r_bp [3], r_cp [3];
    logic signed [2*DW-1:0] r_p [6][3];
    logic signed [PW-1:0] r_d [3:6][6];
    logic [2*SL-1:0] r_ll [6];
    logic signed [SL+HW:0] r_lh [6], r_hl [6];
    logic signed [2*HW-1:0] r_hh [6];
    logic signed [PW:0] r_e43 [4:6], r_e56 [4:6], r_den2 [4:6], r_den4 [4:6];
    logic signed [PW+1:0] r_den5 [5:6];
    logic signed [VW-1:0] r_m [6];
    logic signed [VW-1:0] r_va, r_vb, r_vc;

    t_region r_rg [7:NP];
    logic signed [CW-1:0] r_base [7:NP][3];
    logic signed [FW-1:0] r_den [7:9];
    logic signed [VW-1:0] r_mo [2];
    logic signed [DW-1:0] r_dir [2][3];
    logic signed [SL+DW:0] r_pp [3][2][4];
    logic signed [NW-1:0] r_x [3][2];
    logic signed [NW-1:0] r_n [3];
    logic [FW-2:0] r_dmag [10:NP];
    logic r_dneg;
    logic r_zero [10:NP];
    logic [MW-1:0] r_nmag [3];
    logic r_qneg [11:NP][3];
    logic r_ovf [12:NP][3];
    logic [MW-1:0] r_rem [12:NP][3];
    logic [QW-1:0] r_q [12:NP][3];

    t_region n_rg;
    logic signed [FW-1:0] n_den;
    logic signed [VW-1:0] n_mo [2];
    logic signed [DW-1:0] n_dir [2][3];
    logic signed [CW-1:0] n_base [3];
    logic signed [SL+DW:0] n_pp [3][2][4];
    logic signed [CW-1:0] n_res [3];
    logic d_le [6], d_ge [6];
    logic e43_le, e43_ge, e56_le, e56_ge, va_le, vb_le, vc_le;

    assign in_a[0] = i_data.ax;
    assign in_a[1] = i_data.ay;
    assign in_a[2] = i_data.az;
    assign in_b[0] = i_data.bx;
    assign in_b[1] = i_data.by;
    assign in_b[2] = i_data.bz;
    assign in_c[0] = i_data.cx;
    assign in_c[1] = i_data.cy;
    assign in_c[2] = i_data.cz;
    assign in_p[0] = i_data.px;
    assign in_p[1] = i_data.py;
    assign in_p[2] = i_data.pz;

    // advance the whole pipeline unless the skid slot holds a beat
    assign en      = !r_skid_vld;
    assign o_ready = en;
    assign o_valid = r_out_vld;
    assign o_data  = r_out;

    // region tests on the dot products and determinants
    always_comb begin
        for (int k = 0; k < 6; k++) begin
            d_ge[k] = !r_d[6][k][PW-1];
            d_le[k] = r_d[6][k][PW-1] || (r_d[6][k] == '0);
        end
        e43_ge = !r_e43[6][PW];
        e43_le = r_e43[6][PW] || (r_e43[6] == '0);
        e56_ge = !r_e56[6][PW];
        e56_le = r_e56[6][PW] || (r_e56[6] == '0);
        va_le  = r_va[VW-1] || (r_va == '0);
        vb_le  = r_vb[VW-1] || (r_vb == '0);
        vc_le  = r_vc[VW-1] || (r_vc == '0);

        if (d_le[0] && d_le[1]) begin
            n_rg = REG_A;
        end else if (d_ge[2] && e43_le) begin
            n_rg = REG_B;
        end else if (vc_le && d_ge[0] && d_le[2]) begin
            n_rg = REG_AB;
        end else if (d_ge[5] && e56_le) begin
            n_rg = REG_C;
        end else if (vb_le && d_ge[1] && d_le[5]) begin
            n_rg = REG_AC;
        end else if (va_le && e43_ge && e56_ge) begin
            n_rg = REG_BC;
        end else begin
            n_rg = REG_FACE;
        end
    end

    // pick base, direction, numerator operands and divisor for the region
    always_comb begin
        n_base   = r_a[6];
        n_dir[0] = r_ab[6];
        n_dir[1] = r_ac[6];
        n_mo[0]  = '0;
        n_mo[1]  = '0;
        n_den    = '0;
        case (n_rg)
            REG_A: begin
            end
            REG_B: begin
                n_base = r_b[6];
            end
            REG_C: begin
                n_base = r_c[6];
            end
            REG_AB: begin
                n_mo[0] = VW'(r_d[6][0]);
                n_den   = FW'(r_den2[6]);
            end
            REG_AC: begin
                n_mo[0]  = VW'(r_d[6][1]);
                n_dir[0] = r_ac[6];
                n_den    = FW'(r_den4[6]);
            end
            REG_BC: begin
                n_base   = r_b[6];
                n_mo[0]  = VW'(r_e43[6]);
                n_dir[0] = r_bc[6];
                n_den    = FW'(r_den5[6]);
            end
            REG_FACE: begin
                n_mo[0] = r_vb;
                n_mo[1] = r_vc;
                n_den   = FW'(r_va) + FW'(r_vb) + FW'(r_vc);
            end
            default: begin
            end
        endcase
    end

    // slice the wide operand into four pieces for the direction products
    always_comb begin
        logic signed [4*SL-1:0] mx;
        logic signed [SL:0] ck;
        for (int i = 0; i < 3; i++) begin
            for (int o = 0; o < 2; o++) begin
                mx = (4*SL)'(r_mo[o]);
                for (int k = 0; k < 4; k++) begin
                    if (k == 3) begin
                        ck = (SL+1)'($signed(mx[3*SL +: SL]));
                    end else begin
                        ck = $signed({1'b0, mx[k*SL +: SL]});
                    end
                    n_pp[i][o][k] = ck * r_dir[o][i];
                end
            end
        end
    end

    // apply sign, add base, saturate
    always_comb begin
        logic signed [QW:0] qs;
        logic signed [RSW-1:0] sum;
        for (int i = 0; i < 3; i++) begin
            qs = r_qneg[NP][i] ? -$signed({1'b0, r_q[NP][i]}) : $signed({1'b0, r_q[NP][i]});
            if (r_zero[NP]) begin
                qs = '0;
            end
            sum = RSW'(r_base[NP][i]) + RSW'(qs);
            if (r_ovf[NP][i] && !r_zero[NP]) begin
                n_res[i] = r_qneg[NP][i] ? CO_MIN : CO_MAX;
            end else if (sum > RES_HI) begin
                n_res[i] = CO_MAX;
            end else if (sum < RES_LO) begin
                n_res[i] = CO_MIN;
            end else begin
                n_res[i] = sum[CW-1:0];
            end
        end
        n_out.closest_x  = n_res[0];
        n_out.closest_y  = n_res[1];
        n_out.closest_z  = n_res[2];
        n_out.region     = r_rg[NP];
        n_out.degenerate = (r_rg[NP] == REG_FACE) && r_zero[NP];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            // stage 1: differences
            for (int i = 0; i < 3; i++) begin
                r_a[1][i]  <= in_a[i];
                r_b[1][i]  <= in_b[i];
                r_c[1][i]  <= in_c[i];
                r_ab[1][i] <= DW'(in_b[i]) - DW'(in_a[i]);
                r_ac[1][i] <= DW'(in_c[i]) - DW'(in_a[i]);
                r_bc[1][i] <= DW'(in_c[i]) - DW'(in_b[i]);
                r_ap[i]    <= DW'(in_p[i]) - DW'(in_a[i]);
                r_bp[i]    <= DW'(in_p[i]) - DW'(in_b[i]);
                r_cp[i]    <= DW'(in_p[i]) - DW'(in_c[i]);
            end
            for (int k = 2; k <= 6; k++) begin
                r_a[k]  <= r_a[k-1];
                r_b[k]  <= r_b[k-1];
                r_c[k]  <= r_c[k-1];
                r_ab[k] <= r_ab[k-1];
                r_ac[k] <= r_ac[k-1];
                r_bc[k] <= r_bc[k-1];
            end
            // stage 2: dot product terms
            for (int i = 0; i < 3; i++) begin
                r_p[0][i] <= r_ab[1][i] * r_ap[i];
                r_p[1][i] <= r_ac[1][i] * r_ap[i];
                r_p[2][i] <= r_ab[1][i] * r_bp[i];
                r_p[3][i] <= r_ac[1][i] * r_bp[i];
                r_p[4][i] <= r_ab[1][i] * r_cp[i];
                r_p[5][i] <= r_ac[1][i] * r_cp[i];
            end
            // stage 3: dot products d1..d6
            for (int k = 0; k < 6; k++) begin
                r_d[3][k] <= PW'(r_p[k][0]) + PW'(r_p[k][1]) + PW'(r_p[k][2]);
            end
            for (int s = 4; s <= 6; s++) begin
                r_d[s] <= r_d[s-1];
            end
            // stage 4: partial products of the determinant terms
            for (int m = 0; m < 6; m++) begin
                r_ll[m] <= r_d[3][MX[m]][SL-1:0] * r_d[3][MY[m]][SL-1:0];
                r_lh[m] <= $signed({1'b0, r_d[3][MX[m]][SL-1:0]}) *
                           $signed(r_d[3][MY[m]][PW-1:SL]);
                r_hl[m] <= $signed(r_d[3][MX[m]][PW-1:SL]) *
                           $signed({1'b0, r_d[3][MY[m]][SL-1:0]});
                r_hh[m] <= $signed(r_d[3][MX[m]][PW-1:SL]) *
                           $signed(r_d[3][MY[m]][PW-1:SL]);
            end
            r_e43[4]  <= (PW+1)'(r_d[3][3]) - (PW+1)'(r_d[3][2]);
            r_e56[4]  <= (PW+1)'(r_d[3][4]) - (PW+1)'(r_d[3][5]);
            r_den2[4] <= (PW+1)'(r_d[3][0]) - (PW+1)'(r_d[3][2]);
            r_den4[4] <= (PW+1)'(r_d[3][1]) - (PW+1)'(r_d[3][5]);
            for (int s = 5; s <= 6; s++) begin
                r_e43[s]  <= r_e43[s-1];
                r_e56[s]  <= r_e56[s-1];
                r_den2[s] <= r_den2[s-1];
                r_den4[s] <= r_den4[s-1];
            end
            // stage 5: assemble determinant terms
            for (int m = 0; m < 6; m++) begin
                r_m[m] <= (VW'(r_hh[m]) <<< (2*SL)) +
                          ((VW'(r_lh[m]) + VW'(r_hl[m])) <<< SL) +
                          VW'($signed({1'b0, r_ll[m]}));
            end
            r_den5[5] <= (PW+2)'(r_e43[4]) + (PW+2)'(r_e56[4]);
            r_den5[6] <= r_den5[5];
            // stage 6: determinants
            r_vc <= r_m[0] - r_m[1];
            r_vb <= r_m[2] - r_m[3];
            r_va <= r_m[4] - r_m[5];
            // stage 7: region and operand select
            r_rg[7]   <= n_rg;
            r_base[7] <= n_base;
            r_den[7]  <= n_den;
            r_mo      <= n_mo;
            r_dir     <= n_dir;
            for (int s = 8; s <= NP; s++) begin
                r_rg[s]   <= r_rg[s-1];
                r_base[s] <= r_base[s-1];
            end
            for (int s = 8; s <= 9; s++) begin
                r_den[s] <= r_den[s-1];
            end
            // stage 8: sliced direction products
            r_pp <= n_pp;
            // stage 9: assemble products
            for (int i = 0; i < 3; i++) begin
                for (int o = 0; o < 2; o++) begin
                    r_x[i][o] <= NW'(r_pp[i][o][0]) +
                                 (NW'(r_pp[i][o][1]) <<< SL) +
                                 (NW'(r_pp[i][o][2]) <<< (2*SL)) +
                                 (NW'(r_pp[i][o][3]) <<< (3*SL));
                end
            end
            // stage 10: dividend, divisor magnitude
            for (int i = 0; i < 3; i++) begin
                r_n[i] <= r_x[i][0] + r_x[i][1];
            end
            r_dneg     <= r_den[9][FW-1];
            r_dmag[10] <= r_den[9][FW-1] ? (FW-1)'(-r_den[9]) : (FW-1)'(r_den[9]);
            r_zero[10] <= (r_den[9] == '0);
            for (int s = 11; s <= NP; s++) begin
                r_dmag[s] <= r_dmag[s-1];
                r_zero[s] <= r_zero[s-1];
            end
            // stage 11: dividend magnitude, quotient sign
            for (int i = 0; i < 3; i++) begin
                r_nmag[i]     <= r_n[i][NW-1] ? MW'(-r_n[i]) : MW'(r_n[i]);
                r_qneg[11][i] <= r_n[i][NW-1] ^ r_dneg;
            end
            for (int s = 12; s <= NP; s++) begin
                r_qneg[s] <= r_qneg[s-1];
            end
            // stage 12: quotient range check, load remainder
            for (int i = 0; i < 3; i++) begin
                r_ovf[12][i] <= ({1'b0, r_nmag[i]} >= {r_dmag[11], {QW{1'b0}}});
                r_rem[12][i] <= r_nmag[i];
                r_q[12][i]   <= '0;
            end
            // restoring divide, one quotient bit per stage, MSB first
            for (int s = 13; s <= NP; s++) begin
                r_ovf[s] <= r_ovf[s-1];
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[s-1][i] >= (MW'(r_dmag[s-1]) << (NP - s))) begin
                        r_rem[s][i] <= r_rem[s-1][i] - (MW'(r_dmag[s-1]) << (NP - s));
                        r_q[s][i]   <= r_q[s-1][i] | (QW'(1) << (NP - s));
                    end else begin
                        r_rem[s][i] <= r_rem[s-1][i];
                        r_q[s][i]   <= r_q[s-1][i];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (en) begin
                r_vld <= {r_vld[NP-1:1], i_valid};
            end
            if (r_skid_vld) begin
                if (i_ready) begin
                    r_skid_vld <= 1'b0;
                end
            end else if (r_vld[NP]) begin
                if (!r_out_vld || i_ready) begin
                    r_out_vld <= 1'b1;
                end else begin
                    r_skid_vld <= 1'b1;
                end
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_vld) begin
            if (i_ready) begin
                r_out <= r_skid;
            end
        end else if (r_vld[NP]) begin
            if (!r_out_vld || i_ready) begin
                r_out <= n_out;
            end else begin
                r_skid <= n_out;
            end
        end
    end

endmodule

// ===== design/cpt_checker.sv =====
module cpt_checker
    import cpt_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_valid,
    input logic      o_ready,
    input t_in_beat  i_data,
    input logic      o_valid,
    input logic      i_ready,
    input t_out_beat o_data
);

    logic [7:0] r_cnt, n_cnt;
    logic in_beat, out_beat;

    assign in_beat  = i_valid && o_ready;
    assign out_beat = o_valid && i_ready;

    always_comb begin
        n_cnt = r_cnt + 8'(in_beat) - 8'(out_beat);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data))
        else $error("result changed while stalled");

    a_degen_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.degenerate |-> o_data.region == REG_FACE)
        else $error("degenerate flag outside face region");

    // no result without a beat in flight
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_cnt != 8'd0)
        else $error("result without a pending input beat");

    // drop ready only when the output side is backed up
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_ready |-> o_valid)
        else $error("input stalled with empty output");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

bind closest_point_on_triangle_unit cpt_checker u_cpt_checker (.*);

// ===== tb/tb_closest_point_on_triangle_unit.sv =====
`timescale 1ns / 1ps

module tb_closest_point_on_triangle_unit
    import cpt_pkg::*;
();

    typedef logic signed [255:0] t_wide;

    localparam int LIMIT_CYCLES = 400000;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_beat  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_beat o_data;

    t_out_beat expected_points[$];
    int        mismatch_count;
    int        cycle_count;
    int        send_idle_pct;
    int        recv_idle_pct;
    int        recv_hold_cycles;

    closest_point_on_triangle_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    function automatic logic [CW-1:0] saturate_coord(t_wide v);
        t_wide hi;
        t_wide lo;
        hi = {1'b0, {(CW-1){1'b1}}};
        lo = -hi - 1;
        if (v > hi) return CO_MAX;
        if (v < lo) return CO_MIN;
        return v[CW-1:0];
    endfunction

    function automatic t_wide dot3(t_wide u[3], t_wide v[3]);
        return u[0] * v[0] + u[1] * v[1] + u[2] * v[2];
    endfunction

    function automatic t_out_beat closest_point(t_in_beat x);
        t_wide a[3], b[3], c[3], p[3];
        t_wide ab[3], ac[3], bc[3], ap[3], bp[3], cp[3];
        t_wide base[3], dir[3], res[3];
        t_wide d1, d2, d3, d4, d5, d6, va, vb, vc, num, den;
        t_region rg;
        t_out_beat r;
        a = '{x.ax, x.ay, x.az};
        b = '{x.bx, x.by, x.bz};
        c = '{x.cx, x.cy, x.cz};
        p = '{x.px, x.py, x.pz};
        for (int i = 0; i < 3; i++) begin
            ab[i] = b[i] - a[i];
            ac[i] = c[i] - a[i];
            bc[i] = c[i] - b[i];
            ap[i] = p[i] - a[i];
            bp[i] = p[i] - b[i];
            cp[i] = p[i] - c[i];
        end
        d1 = dot3(ab, ap);
        d2 = dot3(ac, ap);
        d3 = dot3(ab, bp);
        d4 = dot3(ac, bp);
        d5 = dot3(ab, cp);
        d6 = dot3(ac, cp);
        vc = d1 * d4 - d3 * d2;
        vb = d5 * d2 - d1 * d6;
        va = d3 * d6 - d5 * d4;
        num = 0;
        den = 0;
        base = a;
        dir = ab;
        r.degenerate = 1'b0;
        if (d1 <= 0 && d2 <= 0) begin
            rg = REG_A;
        end else if (d3 >= 0 && d4 - d3 <= 0) begin
            rg = REG_B;
            base = b;
        end else if (vc <= 0 && d1 >= 0 && d3 <= 0) begin
            rg = REG_AB;
            num = d1;
            den = d1 - d3;
        end else if (d6 >= 0 && d5 - d6 <= 0) begin
            rg = REG_C;
            base = c;
        end else if (vb <= 0 && d2 >= 0 && d6 <= 0) begin
            rg = REG_AC;
            dir = ac;
            num = d2;
            den = d2 - d6;
        end else if (va <= 0 && d4 - d3 >= 0 && d5 - d6 >= 0) begin
            rg = REG_BC;
            base = b;
            dir = bc;
            num = d4 - d3;
            den = num + (d5 - d6);
        end else begin
            rg = REG_FACE;
        end
        if (rg == REG_FACE) begin
            den = va + vb + vc;
            for (int i = 0; i < 3; i++) begin
                if (den == 0) res[i] = a[i];
                else res[i] = a[i] + (ab[i] * vb + ac[i] * vc) / den;
            end
            r.degenerate = (den == 0);
        end else begin
            for (int i = 0; i < 3; i++)
                res[i] = base[i] + ((den == 0) ? t_wide'(0) : (num * dir[i]) / den);
        end
        r.closest_x = saturate_coord(res[0]);
        r.closest_y = saturate_coord(res[1]);
        r.closest_z = saturate_coord(res[2]);
        r.region = rg;
        return r;
    endfunction

    // Coordinates on one of several scales so that small grids hit ties and zeros.
    function automatic logic [CW-1:0] rand_coord(int scale);
        logic [CW-1:0] v;
        v = $urandom;
        case (scale)
            0: return CW'($signed($urandom_range(0, 8)) - 4);
            1: return CW'($signed($urandom_range(0, 2000)) - 1000) << 16;
            2: return CW'($signed(v) >>> 8);
            default: return v;
        endcase
    endfunction

    function automatic t_in_beat rand_triangle();
        t_in_beat t;
        int scale;
        int k;
        scale = $urandom_range(0, 9);
        scale = (scale < 2) ? 0 : (scale < 6) ? 1 : (scale < 8) ? 2 : 3;
        t = {rand_coord(scale), rand_coord(scale), rand_coord(scale),
             rand_coord(scale), rand_coord(scale), rand_coord(scale),
             rand_coord(scale), rand_coord(scale), rand_coord(scale),
             rand_coord(scale), rand_coord(scale), rand_coord(scale)};
        case ($urandom_range(0, 9))
            0: begin  // collinear vertices
                k = $signed($urandom_range(0, 4)) - 2;
                t.cx = t.ax + k * (t.bx - t.ax);
                t.cy = t.ay + k * (t.by - t.ay);
                t.cz = t.az + k * (t.bz - t.az);
            end
            1: begin  // zero-length edge
                t.bx = t.ax;
                t.by = t.ay;
                t.bz = t.az;
            end
            2: begin
                t.cx = t.bx;
                t.cy = t.by;
                t.cz = t.bz;
            end
            default: ;
        endcase
        return t;
    endfunction

    // leave valid high after the beat; an idle gap in the next send or a drain lowers it
    task automatic send_triangle(t_in_beat t);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= t;
        do @(posedge i_clk); while (!o_ready);
        expected_points.push_back(closest_point(t));
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_tri(input int ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz);
        send_triangle({ax, ay, az, bx, by, bz, cx, cy, cz, px, py, pz});
    endtask

    task automatic test_directed();
        int one;
        int mx;
        int mn;
        one = 32'sh10000;
        mx  = 32'sh7fffffff;
        mn  = 32'sh80000000;
        // unit triangle in the xy plane, P in each region
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, -one, -one, one);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, 2 * one, -one, 0);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, one / 2, -one, 5);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, -one, 2 * one, 0);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, -one, one / 3, -7);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, one, one, one);
        send_tri(0, 0, 0, one, 0, 0, 0, one, 0, one / 4, one / 3, -one);
        send_tri(0, 0, 0, 3 * one, one, 0, one, 3 * one, 2, one, one, 9);
        // degenerate faces: all equal, collinear
        send_tri(5, 6, 7, 5, 6, 7, 5, 6, 7, 100, -100, 3);
        send_tri(0, 0, 0, one, one, one, 2 * one, 2 * one, 2 * one, one, 0, one);
        // zero-length edges
        send_tri(one, 0, 0, one, 0, 0, 0, one, 0, one, -one, 0);
        send_tri(0, 0, 0, one, 0, 0, one, 0, 0, 2 * one, one, 0);
        // coordinate extremes, saturation
        send_tri(mn, mn, mn, mx, mx, mx, mn, mx, mn, mx, mn, mx);
        send_tri(mx, mx, mx, mn, mn, mn, mx, mn, mn, 0, 0, 0);
        send_tri(mn, 0, mx, mx, 0, mn, 0, mx, 0, 0, 0, 0);
        send_tri(mx, mn, 0, mn, mx, 0, mx, mx, 0, 0, 0, mn);
        send_tri(mn, mn, 0, mx, mn, 0, mn, mx, 0, -1, -1, mx);
        send_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1, -1);
        send_tri(mx, mx, mx, mx, mx, mx, mx, mx, mx, mn, mn, mn);
    endtask

    task automatic test_random(int count, int s_idle, int r_idle);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        repeat (count) send_triangle(rand_triangle());
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold_cycles = 300;
        repeat (120) send_triangle(rand_triangle());
        // pause until the pipeline is empty
        drain_results();
        repeat (60) send_triangle(rand_triangle());
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (recv_hold_cycles > 0) begin
            recv_hold_cycles <= recv_hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_points.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result beat %h", o_data);
            end else begin
                want = expected_points.pop_front();
                if (o_data !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: exp x=%h y=%h z=%h rg=%0d dg=%b, got x=%h y=%h z=%h rg=%0d dg=%b",
                                 want.closest_x, want.closest_y, want.closest_z,
                                 want.region, want.degenerate,
                                 o_data.closest_x, o_data.closest_y, o_data.closest_z,
                                 o_data.region, o_data.degenerate);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial begin
        mismatch_count   = 0;
        cycle_count      = 0;
        send_idle_pct    = 0;
        recv_idle_pct    = 0;
        recv_hold_cycles = 0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data  = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(700, 33, 55);
        test_random(700, 55, 33);
        test_backpressure();
        test_random(500, 0, 0);
        drain_results();
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0 && expected_points.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/cpt_pkg.sv
design/closest_point_on_triangle_unit.sv
design/cpt_checker.sv
tb/tb_closest_point_on_triangle_unit.sv
